[rtl/core/periodic_task_timer_table_core_macros.svh]
// Assertion macros used by the checker file.
// Included by bare name; no other dependencies.
`ifndef PERIODIC_TASK_TIMER_TABLE_CORE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_CORE_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define PTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/ptt_pkg.sv]
// Shared types and constants for the periodic task timer table.
// No dependencies.
package ptt_pkg;
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_ADD     = 3'd1;
  localparam logic [2:0] KIND_PAUSE   = 3'd2;
  localparam logic [2:0] KIND_RESTART = 3'd3;
  localparam logic [2:0] KIND_MODIFY  = 3'd4;
  localparam logic [2:0] KIND_REMOVE  = 3'd5;
  localparam logic [2:0] KIND_QUERY   = 3'd6;
  localparam logic [2:0] KIND_UNUSED  = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] MODE_PAUSED   = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_ONESHOT  = 2'd2;

  localparam logic [31:0] MAX_INTERVAL_RST     = 32'd3600000;
  localparam logic [31:0] DEFAULT_INTERVAL_RST = 32'd50;
  localparam int unsigned MAX_RESULTS = 16;

  localparam logic CFG_MAX_INTERVAL = 1'b0;
  localparam logic CFG_DEFAULT_INTERVAL = 1'b1;

  typedef struct packed {
    logic [7:0]  id;
    logic [1:0]  mode;
    logic [31:0] interval;
    logic [31:0] due;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CHK, S_OP_WR,
    S_TICK_RD, S_TICK_CHK, S_SHIFT_RD, S_SHIFT_WR, S_OUT, S_TICK_END
  } state_t;

  typedef struct packed {
    logic        fired;
    logic [7:0]  task_id;
    logic [1:0]  status;
    logic [1:0]  mode;
    logic        last;
  } result_t;
endpackage

[rtl/core/periodic_task_timer_table_core.sv]
// Periodic task timer table.
// Input channel in_*: kind, task_id, interval, mode; valid/stall handshake.
// Result channel out_*: fired, result_task, status_code, task_mode, last.
// cfg_*: plain write port, index 0 max_interval, index 1 default_interval.
// One item is processed at a time; in_stall is high while an item is at work.
// Operations: a sequential search reads one entry per cycle; the single result
// is valid in the cycle after acceptance (empty, full), else after the search
// or the write; a remove moves each later entry down, a read and a write each.
// Tick: each entry passes a memory read and a check state; a one-time entry
// that fires is compacted out by moving each later entry down, with a read
// and a write per moved entry.
// A fired result is held back until the next firing or the end of the scan,
// so the final one can carry last. Every result sits in an output register;
// when out_stall is high the block holds it and waits, the scan resumes once it is taken.
// Reset clears the tick count, the entry count, the state, config and valid
// registers to their defaults; entry storage is left as it is, only entries
// below the count are ever used. Unused kind 7 is taken and yields no result.
module periodic_task_timer_table_core #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_task_id,
  input  logic [31:0] in_interval,
  input  logic [2:0]  in_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_fired,
  output logic [7:0]  out_result_task,
  output logic [1:0]  out_status_code,
  output logic [1:0]  out_task_mode,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int unsigned AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);
  localparam logic [4:0] MAXRES_C = 5'(ptt_pkg::MAX_RESULTS);

  ptt_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [31:0] maxi_r, defi_r, tick_r, tick_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt, sh_r, sh_nxt;
  logic [4:0] nres_r, nres_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [7:0] id_r, id_nxt;
  logic [31:0] ival_r, ival_nxt;
  logic [2:0] mode_r, mode_nxt;
  ptt_pkg::entry_t ent_r, ent_nxt;
  ptt_pkg::result_t res_r, res_nxt;
  ptt_pkg::result_t pres_r, pres_nxt;
  logic pend_r, pend_nxt;
  logic ovalid_r, ovalid_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  ptt_pkg::entry_t wdata, rdata;
  logic [31:0] diff;
  logic [31:0] addv;

  ptt_mem #(.DEPTH(TASK_SLOTS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptt_pkg::S_IDLE;
      ret_r <= ptt_pkg::S_IDLE;
      maxi_r <= ptt_pkg::MAX_INTERVAL_RST;
      defi_r <= ptt_pkg::DEFAULT_INTERVAL_RST;
      tick_r <= '0;
      cnt_r <= '0;
      pend_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      tick_r <= tick_nxt;
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ptt_pkg::CFG_MAX_INTERVAL: maxi_r <= cfg_data;
          ptt_pkg::CFG_DEFAULT_INTERVAL: defi_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sh_r <= sh_nxt;
    nres_r <= nres_nxt;
    kind_r <= kind_nxt;
    id_r <= id_nxt;
    ival_r <= ival_nxt;
    mode_r <= mode_nxt;
    ent_r <= ent_nxt;
    res_r <= res_nxt;
    pres_r <= pres_nxt;
  end

  assign diff = tick_r - rdata.due;
  assign in_stall = (state_r != ptt_pkg::S_IDLE) || ovalid_r;
  assign out_valid = ovalid_r;
  assign out_fired = res_r.fired;
  assign out_result_task = res_r.task_id;
  assign out_status_code = res_r.status;
  assign out_task_mode = res_r.mode;
  assign out_last = res_r.last;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    tick_nxt = tick_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    sh_nxt = sh_r;
    nres_nxt = nres_r;
    kind_nxt = kind_r;
    id_nxt = id_r;
    ival_nxt = ival_r;
    mode_nxt = mode_r;
    ent_nxt = ent_r;
    res_nxt = res_r;
    pres_nxt = pres_r;
    pend_nxt = pend_r;
    ovalid_nxt = ovalid_r && out_stall;
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = ent_r;
    raddr = idx_r[AW-1:0];
    addv = '0;
    unique case (state_r)
      ptt_pkg::S_IDLE: begin
        if (in_valid && !in_stall) begin
          kind_nxt = in_kind;
          id_nxt = in_task_id;
          ival_nxt = in_interval;
          mode_nxt = in_mode;
          idx_nxt = '0;
          nres_nxt = '0;
          pend_nxt = 1'b0;
          raddr = '0;
          res_nxt = '{fired: 1'b0, task_id: in_task_id, status: ptt_pkg::ST_OK,
                      mode: ptt_pkg::MODE_PAUSED, last: 1'b1};
          if (in_kind == ptt_pkg::KIND_TICK) begin
            tick_nxt = tick_r + 32'd1;
            state_nxt = (cnt_r != '0) ? ptt_pkg::S_TICK_RD : ptt_pkg::S_IDLE;
          end else if (in_kind == ptt_pkg::KIND_ADD) begin
            if (cnt_r >= SLOTS_C) begin
              res_nxt.status = ptt_pkg::ST_FULL;
              ovalid_nxt = 1'b1;
            end else begin
              ent_nxt.id = in_task_id;
              ent_nxt.mode = (in_mode[1:0] == 2'd3) ? ptt_pkg::MODE_PERIODIC
                                                    : in_mode[1:0];
              ent_nxt.interval = (in_interval == '0 || in_interval > maxi_r)
                                 ? defi_r : in_interval;
              idx_nxt = cnt_r;
              state_nxt = ptt_pkg::S_OP_WR;
            end
          end else if (in_kind <= ptt_pkg::KIND_QUERY) begin
            if (cnt_r == '0) begin
              res_nxt.status = ptt_pkg::ST_EMPTY;
              ovalid_nxt = 1'b1;
            end else begin
              state_nxt = ptt_pkg::S_FIND_RD;
            end
          end
        end
      end
      ptt_pkg::S_FIND_RD: begin
        // raddr = idx_r; data arrives next cycle
        state_nxt = ptt_pkg::S_FIND_CHK;
      end
      ptt_pkg::S_FIND_CHK: begin
        if (rdata.id == id_r) begin
          ent_nxt = rdata;
          unique case (kind_r)
            ptt_pkg::KIND_PAUSE: begin
              ent_nxt.mode = ptt_pkg::MODE_PAUSED;
              state_nxt = ptt_pkg::S_OP_WR;
            end
            ptt_pkg::KIND_RESTART: begin
              ent_nxt.mode = ptt_pkg::MODE_PERIODIC;
              addv = (ival_r == '0) ? rdata.interval : ival_r;
              ent_nxt.due = tick_r + addv;
              state_nxt = ptt_pkg::S_OP_WR;
            end
            ptt_pkg::KIND_MODIFY: begin
              ent_nxt.interval = ival_r;
              if (mode_r <= 3'd2) ent_nxt.mode = mode_r[1:0];
              ent_nxt.due = tick_r + ival_r;
              state_nxt = ptt_pkg::S_OP_WR;
            end
            ptt_pkg::KIND_REMOVE: begin
              sh_nxt = idx_r;
              ret_nxt = ptt_pkg::S_OUT;
              state_nxt = ptt_pkg::S_SHIFT_RD;
            end
            default: begin
              res_nxt.mode = rdata.mode;
              ovalid_nxt = 1'b1;
              state_nxt = ptt_pkg::S_IDLE;
            end
          endcase
        end else if (idx_r + CW'(1) >= cnt_r) begin
          res_nxt.status = ptt_pkg::ST_NOTFOUND;
          ovalid_nxt = 1'b1;
          state_nxt = ptt_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
          raddr = idx_nxt[AW-1:0];
          state_nxt = ptt_pkg::S_FIND_CHK;
        end
      end
      ptt_pkg::S_OP_WR: begin
        we = 1'b1;
        if (kind_r == ptt_pkg::KIND_ADD) begin
          wdata.due = tick_r + (mode_r[2] ? 32'd0 : ent_r.interval);
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = ptt_pkg::S_OUT;
      end
      ptt_pkg::S_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          state_nxt = ptt_pkg::S_IDLE;
        end
      end
      ptt_pkg::S_TICK_RD: begin
        // wait for any pending result to leave before reporting more
        if (!ovalid_r || !out_stall) begin
          state_nxt = ptt_pkg::S_TICK_CHK;
        end
      end
      ptt_pkg::S_TICK_CHK: begin
        if (rdata.mode != ptt_pkg::MODE_PAUSED && !diff[31]) begin
          // the held firing is not the last one: send it now
          if (pend_r) begin
            res_nxt = pres_r;
            ovalid_nxt = 1'b1;
          end
          pres_nxt = '{fired: 1'b1, task_id: rdata.id, status: ptt_pkg::ST_OK,
                       mode: rdata.mode, last: 1'b0};
          pend_nxt = 1'b1;
          nres_nxt = nres_r + 5'd1;
          if (rdata.mode == ptt_pkg::MODE_ONESHOT) begin
            sh_nxt = idx_r;
            ret_nxt = ptt_pkg::S_TICK_RD;
            state_nxt = ptt_pkg::S_SHIFT_RD;
          end else begin
            we = 1'b1;
            wdata = rdata;
            wdata.due = tick_r + rdata.interval;
            idx_nxt = idx_r + CW'(1);
            state_nxt = ptt_pkg::S_TICK_RD;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          state_nxt = ptt_pkg::S_TICK_RD;
        end
        // end of scan; after a removal the check is made once the count drops
        if (state_nxt == ptt_pkg::S_TICK_RD &&
            (idx_nxt >= cnt_r || nres_nxt >= MAXRES_C)) begin
          state_nxt = ptt_pkg::S_TICK_END;
        end
        raddr = idx_nxt[AW-1:0];
      end
      ptt_pkg::S_TICK_END: begin
        // send the held firing, marked last
        if (!ovalid_r || !out_stall) begin
          if (pend_r) begin
            res_nxt = pres_r;
            res_nxt.last = 1'b1;
            ovalid_nxt = 1'b1;
          end
          pend_nxt = 1'b0;
          state_nxt = ptt_pkg::S_IDLE;
        end
      end
      ptt_pkg::S_SHIFT_RD: begin
        // read entry sh+1 to move it down
        if (sh_r + CW'(1) >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          if (ret_r == ptt_pkg::S_TICK_RD) begin
            raddr = idx_r[AW-1:0];
            if (idx_r >= cnt_nxt || nres_r >= MAXRES_C) begin
              state_nxt = ptt_pkg::S_TICK_END;
            end else begin
              state_nxt = ptt_pkg::S_TICK_RD;
            end
          end else begin
            state_nxt = ret_r;
          end
        end else begin
          raddr = AW'(sh_r + CW'(1));
          state_nxt = ptt_pkg::S_SHIFT_WR;
        end
      end
      ptt_pkg::S_SHIFT_WR: begin
        we = 1'b1;
        waddr = sh_r[AW-1:0];
        wdata = rdata;
        sh_nxt = sh_r + CW'(1);
        state_nxt = ptt_pkg::S_SHIFT_RD;
      end
      default: state_nxt = ptt_pkg::S_IDLE;
    endcase
  end
endmodule

[rtl/core/ptt_mem.sv]
// Entry store: one synchronous memory, one write and one read port.
// Depends on ptt_pkg.
module ptt_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  ptt_pkg::entry_t      wdata,
  input  logic [AW-1:0]        raddr,
  output ptt_pkg::entry_t      rdata
);
  ptt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/ptt_checker.sv]
// Port-level checker for the timer table, bound to the top level.
// Depends on periodic_task_timer_table_core_macros.svh and ptt_pkg.
`include "periodic_task_timer_table_core_macros.svh"
module ptt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_fired,
  input logic [1:0] out_status_code,
  input logic       out_last
);
  `PTT_ASSERT_IMP(a_fired_ok, clk, rst_n, out_valid && out_fired, out_status_code == ptt_pkg::ST_OK)
  `PTT_ASSERT_IMP(a_op_last, clk, rst_n, out_valid && !out_fired, out_last)
  `PTT_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid)
  `PTT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule

bind periodic_task_timer_table_core ptt_checker u_ptt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_fired(out_fired),
  .out_status_code(out_status_code), .out_last(out_last)
);
